/* design/vvfe_pkg.sv */
package vvfe_pkg;

   // field widths on the streaming ports
   localparam int unsigned COORD_X_W = 4;
   localparam int unsigned COORD_Y_W = 6;
   localparam int unsigned COORD_Z_W = 4;
   localparam int unsigned BTYPE_W   = 2;
   localparam int unsigned DIR_W     = 3;
   localparam int unsigned NUM_DIRS  = 6;

   // request kinds carried on tuser
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // face normal codes, also the emit order
   localparam logic [DIR_W-1:0] DIR_POS_Y = 3'd0;
   localparam logic [DIR_W-1:0] DIR_NEG_Y = 3'd1;
   localparam logic [DIR_W-1:0] DIR_POS_X = 3'd2;
   localparam logic [DIR_W-1:0] DIR_NEG_X = 3'd3;
   localparam logic [DIR_W-1:0] DIR_POS_Z = 3'd4;
   localparam logic [DIR_W-1:0] DIR_NEG_Z = 3'd5;

   // air
   localparam logic [BTYPE_W-1:0] BTYPE_AIR = 2'd0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

endpackage

/* design/voxel_visible_face_extract_top.sv */
// voxel visible face extractor: holds one chunk of CHUNK_WIDTH x CHUNK_HEIGHT x CHUNK_WIDTH
// cells of 2-bit block type (0 = air) in a block memory with one write and one read port.
// a load request (req_tuser = 0) writes one cell; the block stays ready. a query
// request (req_tuser = 1) walks seven reads of the same memory port (the cell, then its
// +y, -y, +x, -x, +z, -z neighbours), one per cycle, then emits one record per cycle while
// the receiver takes them (up to six) in the order +y, -y, +x, -x, +z, -z with rsp_tlast
// on the final one; the single memory read port sets the pace of the reads.
// a query holds off the next request until its last record is issued; output stalls
// lengthen that. a query of an air cell, an all-covered cell, or any request with a
// coordinate outside the chunk gives no records. neighbours past the chunk edge count as
// air. cells must be loaded before a query reads them; the store has no reset.
module voxel_visible_face_extract_top #(
   parameter int unsigned CHUNK_WIDTH  = 16,
   parameter int unsigned CHUNK_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cell_x[3:0], cell_y[9:4], cell_z[13:10], load_type[15:14]
   input  logic        req_tuser,   // func: 0 load, 1 query
   // face record channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // face_x[3:0], face_y[9:4], face_z[13:10],
                                    // face_dir[16:14], face_type[18:17], zero[23:19]
   output logic        rsp_tlast    // last_face
);

   // address pieces per axis
   localparam int unsigned XW  = $clog2(CHUNK_WIDTH);
   localparam int unsigned YW  = $clog2(CHUNK_HEIGHT);
   localparam int unsigned AW  = 2 * XW + YW;
   localparam int unsigned DEPTH = 2 ** AW;
   // coordinate registers wide enough for the port field and the chunk size
   localparam int unsigned XEW = (XW > vvfe_pkg::COORD_X_W) ? XW : vvfe_pkg::COORD_X_W;
   localparam int unsigned YEW = (YW > vvfe_pkg::COORD_Y_W) ? YW : vvfe_pkg::COORD_Y_W;
   localparam int unsigned ZEW = (XW > vvfe_pkg::COORD_Z_W) ? XW : vvfe_pkg::COORD_Z_W;

   // unpack request
   logic [vvfe_pkg::COORD_X_W-1:0] req_x;
   logic [vvfe_pkg::COORD_Y_W-1:0] req_y;
   logic [vvfe_pkg::COORD_Z_W-1:0] req_z;
   logic [vvfe_pkg::BTYPE_W-1:0]   req_type;
   assign req_x    = req_tdata[3:0];
   assign req_y    = req_tdata[9:4];
   assign req_z    = req_tdata[13:10];
   assign req_type = req_tdata[15:14];

   logic req_fire;
   logic in_range;
   assign req_fire = req_tvalid && req_tready;
   // 9 bits holds every chunk size up to 511
   assign in_range = (9'(req_x) < 9'(CHUNK_WIDTH)) && (9'(req_y) < 9'(CHUNK_HEIGHT))
                     && (9'(req_z) < 9'(CHUNK_WIDTH));

   logic [XEW-1:0] req_x_ext;
   logic [YEW-1:0] req_y_ext;
   logic [ZEW-1:0] req_z_ext;
   assign req_x_ext = XEW'(req_x);
   assign req_y_ext = YEW'(req_y);
   assign req_z_ext = ZEW'(req_z);

   // sequencer state
   vvfe_pkg::state_type state_ff, state_in;
   logic [2:0]                    step_ff, step_in;
   logic [XEW-1:0]                x_ff, x_in;
   logic [YEW-1:0]                y_ff, y_in;
   logic [ZEW-1:0]                z_ff, z_in;
   logic [vvfe_pkg::BTYPE_W-1:0]  type_ff, type_in;
   logic [vvfe_pkg::NUM_DIRS-1:0] vis_ff, vis_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   // voxel store
   logic [vvfe_pkg::BTYPE_W-1:0] store_mem [DEPTH];
   logic [vvfe_pkg::BTYPE_W-1:0] rd_data_ff;
   logic [AW-1:0]                rd_addr;
   logic [AW-1:0]                wr_addr;
   logic                         wr_en;

   assign wr_en   = req_fire && (req_tuser == vvfe_pkg::FUNC_LOAD) && in_range;
   assign wr_addr = {req_x_ext[XW-1:0], req_y_ext[YW-1:0], req_z_ext[XW-1:0]};

   // chunk edge flags in face order
   logic [vvfe_pkg::NUM_DIRS-1:0] edge_flag;
   assign edge_flag[vvfe_pkg::DIR_POS_Y] = (y_ff == YEW'(CHUNK_HEIGHT - 1));
   assign edge_flag[vvfe_pkg::DIR_NEG_Y] = (y_ff == '0);
   assign edge_flag[vvfe_pkg::DIR_POS_X] = (x_ff == XEW'(CHUNK_WIDTH - 1));
   assign edge_flag[vvfe_pkg::DIR_NEG_X] = (x_ff == '0);
   assign edge_flag[vvfe_pkg::DIR_POS_Z] = (z_ff == ZEW'(CHUNK_WIDTH - 1));
   assign edge_flag[vvfe_pkg::DIR_NEG_Z] = (z_ff == '0);

   // shared read port: step 0 is the cell, steps 1..6 its neighbours;
   // a neighbour past the edge wraps but its data is overridden by the edge flag
   logic [XW-1:0] ax;
   logic [YW-1:0] ay;
   logic [XW-1:0] az;
   always_comb begin
      ax = x_ff[XW-1:0];
      ay = y_ff[YW-1:0];
      az = z_ff[XW-1:0];
      case (step_ff)
         3'd1: begin
            ay = ay + YW'(1);
         end
         3'd2: begin
            ay = ay - YW'(1);
         end
         3'd3: begin
            ax = ax + XW'(1);
         end
         3'd4: begin
            ax = ax - XW'(1);
         end
         3'd5: begin
            az = az + XW'(1);
         end
         3'd6: begin
            az = az - XW'(1);
         end
         default: begin
         end
      endcase
      rd_addr = {ax, ay, az};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= req_type;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // lowest pending face picks the next record
   logic [vvfe_pkg::DIR_W-1:0]    sel_dir;
   logic [vvfe_pkg::NUM_DIRS-1:0] sel_bit;
   logic [vvfe_pkg::NUM_DIRS-1:0] vis_rest;
   always_comb begin
      sel_dir = vvfe_pkg::DIR_POS_Y;
      for (int i = vvfe_pkg::NUM_DIRS - 1; i >= 0; i--) begin
         if (vis_ff[i]) begin
            sel_dir = vvfe_pkg::DIR_W'(i);
         end
      end
      sel_bit  = vvfe_pkg::NUM_DIRS'(1) << sel_dir;
      vis_rest = vis_ff & ~sel_bit;
   end

   logic       out_free;
   logic [2:0] cap_idx;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign cap_idx  = step_ff - 3'd2;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      type_in      = type_ff;
      vis_in       = vis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;

      case (state_ff)
         vvfe_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire && (req_tuser == vvfe_pkg::FUNC_QUERY) && in_range) begin
               x_in     = req_x_ext;
               y_in     = req_y_ext;
               z_in     = req_z_ext;
               step_in  = 3'd0;
               state_in = vvfe_pkg::ST_READ;
            end
         end
         vvfe_pkg::ST_READ: begin
            // data of step n-1 arrives while step n is issued
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd1) begin
               type_in = rd_data_ff;
            end else if (step_ff >= 3'd2) begin
               vis_in[cap_idx] = edge_flag[cap_idx]
                                 || (rd_data_ff == vvfe_pkg::BTYPE_AIR);
            end
            if (step_ff == 3'd7) begin
               state_in = vvfe_pkg::ST_EMIT;
            end
         end
         vvfe_pkg::ST_EMIT: begin
            if ((type_ff == vvfe_pkg::BTYPE_AIR) || (vis_ff == '0)) begin
               state_in = vvfe_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, type_ff, sel_dir, z_ff[vvfe_pkg::COORD_Z_W-1:0],
                               y_ff[vvfe_pkg::COORD_Y_W-1:0],
                               x_ff[vvfe_pkg::COORD_X_W-1:0]};
               rsp_last_in  = (vis_rest == '0);
               vis_in       = vis_rest;
               if (vis_rest == '0) begin
                  state_in = vvfe_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = vvfe_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vvfe_pkg::ST_IDLE;
         step_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      type_ff     <= type_in;
      vis_ff      <= vis_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // a record always carries a solid type
   a_solid_type: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[18:17] != vvfe_pkg::BTYPE_AIR))
      else $error("face record with air type");

   // each emitted record retires exactly one pending face
   a_emit_retire: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vvfe_pkg::ST_EMIT && type_ff != vvfe_pkg::BTYPE_AIR
       && vis_ff != '0 && out_free)
      |=> ($countones(vis_ff) == $countones($past(vis_ff)) - 1) && rsp_tvalid)
      else $error("face mask did not shrink by one on emit");

   // the last record leaves no pending faces and returns to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vvfe_pkg::ST_EMIT && rsp_valid_in && out_free && rsp_last_in)
      |=> (state_ff == vvfe_pkg::ST_IDLE) && rsp_tlast)
      else $error("last face not followed by idle");
`endif

endmodule

/* dv/voxel_visible_face_extract_top_test.sv */
module voxel_visible_face_extract_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   // chunk geometry, matches the instance parameters below
   localparam int CHUNK_W    = 16;
   localparam int CHUNK_H    = 64;
   localparam int CELL_COUNT = CHUNK_W * CHUNK_H * CHUNK_W;
   localparam int CLK_PERIOD = 4;
   localparam int RESET_CYCLES = 11;
   // request count after which the sender is stimulated to stop
   localparam int TOTAL_REQS = 376;
   // receiver holds off this long once, to back the block up into its input
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int LONG_HOLD_AFTER  = 120;

   // one request as offered on the request channel
   typedef struct packed {
      logic                           func;
      logic [vvfe_pkg::COORD_X_W-1:0] x;
      logic [vvfe_pkg::COORD_Y_W-1:0] y;
      logic [vvfe_pkg::COORD_Z_W-1:0] z;
      logic [vvfe_pkg::BTYPE_W-1:0]   ltype;
      bit                             drain_first;   // sender waits for all faces first
   } req_item_type;

   // one face record as seen on the response channel
   typedef struct packed {
      logic [vvfe_pkg::COORD_X_W-1:0] x;
      logic [vvfe_pkg::COORD_Y_W-1:0] y;
      logic [vvfe_pkg::COORD_Z_W-1:0] z;
      logic [vvfe_pkg::DIR_W-1:0]     dir;
      logic [vvfe_pkg::BTYPE_W-1:0]   btype;
      logic                           last;
   } face_rec_type;

   typedef struct {
      int x;
      int y;
      int z;
   } cell_pos_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // cell_x[3:0], cell_y[9:4], cell_z[13:10], load_type[15:14]
   logic        req_tuser = 1'b0;  // func: 0 load, 1 query
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // face_x[3:0], face_y[9:4], face_z[13:10],
                                   // face_dir[16:14], face_type[18:17], zero[23:19]
   logic        rsp_tlast;         // last_face

   voxel_visible_face_extract_top #(
      .CHUNK_WIDTH (CHUNK_W),
      .CHUNK_HEIGHT(CHUNK_H)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // stimulus and prediction state
   req_item_type                 pending_reqs[$];     // requests not yet offered
   face_rec_type                 expected_faces[$];   // faces predicted but not yet seen
   logic [vvfe_pkg::BTYPE_W-1:0] chunk_model[CELL_COUNT];
   bit                           cell_loaded[CELL_COUNT];  // generator side: cells written
   cell_pos_type                 built_cells[$];      // centers whose neighborhood is loaded

   int gen_total;
   int requests_accepted;
   int load_count;
   int query_count;
   int silent_queries;
   int face_count;
   int error_count;

   // driver state
   req_item_type offered_req;
   bit           offering;
   int           burst_left = 1;
   int           gap_left;

   // receiver state
   logic [9:0] rx_cycle;
   int         hold_left;
   bit         long_hold_done;
   bit         ready_next;

   function automatic int cell_index(input int x, input int y, input int z);
      return (x * CHUNK_H + y) * CHUNK_W + z;
   endfunction

   // step one cell along a face normal; returns 0 when the step leaves the chunk
   function automatic bit neighbor_of(input int x, input int y, input int z, input int dir,
                                      output int nx, output int ny, output int nz);
      nx = x;
      ny = y;
      nz = z;
      case (dir)
         vvfe_pkg::DIR_POS_Y: ny = y + 1;
         vvfe_pkg::DIR_NEG_Y: ny = y - 1;
         vvfe_pkg::DIR_POS_X: nx = x + 1;
         vvfe_pkg::DIR_NEG_X: nx = x - 1;
         vvfe_pkg::DIR_POS_Z: nz = z + 1;
         vvfe_pkg::DIR_NEG_Z: nz = z - 1;
         default: ;
      endcase
      return nx >= 0 && nx < CHUNK_W && ny >= 0 && ny < CHUNK_H && nz >= 0 && nz < CHUNK_W;
   endfunction

   // update the chunk copy on a load, or queue the faces a query should produce
   task automatic predict_faces(input req_item_type r);
      logic [vvfe_pkg::BTYPE_W-1:0]  own_type;
      logic [vvfe_pkg::NUM_DIRS-1:0] visible;
      face_rec_type                  f;
      int                            nx, ny, nz;
      int                            last_dir;
      visible  = '0;
      last_dir = -1;
      if (r.func == vvfe_pkg::FUNC_LOAD) begin
         chunk_model[cell_index(r.x, r.y, r.z)] = r.ltype;
         load_count++;
         return;
      end
      query_count++;
      own_type = chunk_model[cell_index(r.x, r.y, r.z)];
      // past the chunk edge counts as air, so the face shows
      if (own_type != vvfe_pkg::BTYPE_AIR) begin
         for (int d = 0; d < vvfe_pkg::NUM_DIRS; d++) begin
            if (!neighbor_of(r.x, r.y, r.z, d, nx, ny, nz) ||
                chunk_model[cell_index(nx, ny, nz)] == vvfe_pkg::BTYPE_AIR) begin
               visible[d] = 1'b1;
               last_dir   = d;
            end
         end
      end
      if (last_dir < 0) begin
         silent_queries++;
         return;
      end
      for (int d = 0; d < vvfe_pkg::NUM_DIRS; d++) begin
         if (visible[d]) begin
            f.x     = r.x;
            f.y     = r.y;
            f.z     = r.z;
            f.dir   = vvfe_pkg::DIR_W'(d);
            f.btype = own_type;
            f.last  = (d == last_dir);
            expected_faces.push_back(f);
         end
      end
   endtask

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: face %s mismatch, expected %0d actual %0d", $time, field, want, got);
         error_count++;
      end
   endfunction

   // append one request; two of them ask the sender to drain first
   task automatic queue_request(input logic func, input int x, input int y, input int z,
                                input int t);
      req_item_type r;
      r.func        = func;
      r.x           = vvfe_pkg::COORD_X_W'(x);
      r.y           = vvfe_pkg::COORD_Y_W'(y);
      r.z           = vvfe_pkg::COORD_Z_W'(z);
      r.ltype       = vvfe_pkg::BTYPE_W'(t);
      r.drain_first = (gen_total == 100 || gen_total == 280);
      pending_reqs.push_back(r);
      if (func == vvfe_pkg::FUNC_LOAD)
         cell_loaded[cell_index(x, y, z)] = 1'b1;
      gen_total++;
   endtask

   task automatic queue_query(input int x, input int y, input int z);
      queue_request(vvfe_pkg::FUNC_QUERY, x, y, z, $urandom_range(0, 3));
   endtask

   // load a center cell and its in-chunk neighbors; already loaded neighbors are
   // sometimes kept so earlier content carries over
   task automatic load_neighborhood(input int x, input int y, input int z, input int center_type,
                                    input int air_pct, input bit refresh_all);
      int nx, ny, nz;
      queue_request(vvfe_pkg::FUNC_LOAD, x, y, z, center_type);
      for (int d = 0; d < vvfe_pkg::NUM_DIRS; d++) begin
         if (neighbor_of(x, y, z, d, nx, ny, nz) &&
             (refresh_all || !cell_loaded[cell_index(nx, ny, nz)] || $urandom_range(0, 1))) begin
            queue_request(vvfe_pkg::FUNC_LOAD, nx, ny, nz,
                          ($urandom_range(1, 100) <= air_pct) ? 0 : $urandom_range(1, 3));
         end
      end
   endtask

   // leans toward the chunk faces so edge handling gets plenty of traffic
   function automatic int pick_coord(input int limit);
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(0, 1) ? limit : 0;
      return $urandom_range(0, limit);
   endfunction

   // request driver: bursts of random length with random gaps, valid held until taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offering = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_faces(offered_req);
            requests_accepted++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain_first && expected_faces.size() != 0)) begin
               offered_req = pending_reqs.pop_front();
               offering    = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  // some bursts run back to back with no gap at all
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 7);
               end
            end
         end
         req_tvalid <= offering;
         req_tdata  <= {offered_req.ltype, offered_req.z, offered_req.y, offered_req.x};
         req_tuser  <= offered_req.func;
      end
   end

   // face monitor and receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_cycle   <= '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            face_count++;
            if (expected_faces.size() == 0) begin
               $display("%0t ns: unexpected face, expected none actual x=%0d y=%0d z=%0d dir=%0d",
                        $time, rsp_tdata[3:0], rsp_tdata[9:4], rsp_tdata[13:10],
                        rsp_tdata[16:14]);
               error_count++;
            end else begin
               face_rec_type want;
               want = expected_faces.pop_front();
               check_field("x", want.x, rsp_tdata[3:0]);
               check_field("y", want.y, rsp_tdata[9:4]);
               check_field("z", want.z, rsp_tdata[13:10]);
               check_field("dir", want.dir, rsp_tdata[16:14]);
               check_field("type", want.btype, rsp_tdata[18:17]);
               check_field("last", want.last, rsp_tlast);
            end
         end
         // one long hold-off partway through while the sender keeps offering
         if (!long_hold_done && requests_accepted >= LONG_HOLD_AFTER) begin
            hold_left      = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            case (rx_cycle[9:8])
               2'd0: ready_next = 1'b1;
               2'd1: ready_next = ($urandom_range(0, 9) < 7);
               2'd2: ready_next = (rx_cycle[1:0] != 2'd3);
               default: ready_next = ($urandom_range(0, 9) < 3);
            endcase
         end
         rx_cycle   <= rx_cycle + 1'b1;
         rsp_tready <= ready_next;
      end
   end

   // stimulus build and end of run
   initial begin
      int           x, y, z, roll;
      cell_pos_type p;

      // directed: bottom corner with all neighbors air shows all six faces
      load_neighborhood(0, 0, 0, 3, 100, 1'b1);
      queue_query(0, 0, 0);
      // top corner with solid neighbors shows only the three faces past the edges
      load_neighborhood(CHUNK_W - 1, CHUNK_H - 1, CHUNK_W - 1, 1, 0, 1'b1);
      queue_query(CHUNK_W - 1, CHUNK_H - 1, CHUNK_W - 1);
      // interior cell fully enclosed gives nothing
      load_neighborhood(5, 20, 7, 2, 0, 1'b1);
      queue_query(5, 20, 7);
      // query of an air cell gives nothing
      queue_request(vvfe_pkg::FUNC_LOAD, 0, 0, 0, vvfe_pkg::BTYPE_AIR);
      queue_query(0, 0, 0);
      // open one side of the enclosed cell: a single face, marked last
      queue_request(vvfe_pkg::FUNC_LOAD, 5, 20, 6, vvfe_pkg::BTYPE_AIR);
      queue_query(5, 20, 7);

      // random: mostly well-formed neighborhoods then a query, plus revisit queries and stray loads
      while (gen_total < TOTAL_REQS) begin
         roll = $urandom_range(0, 99);
         if (roll < 60 || built_cells.size() == 0) begin
            x = pick_coord(CHUNK_W - 1);
            y = pick_coord(CHUNK_H - 1);
            z = pick_coord(CHUNK_W - 1);
            load_neighborhood(x, y, z, $urandom_range(0, 3), $urandom_range(0, 70),
                              $urandom_range(0, 3) == 0);
            queue_query(x, y, z);
            if ($urandom_range(0, 4) == 0)
               queue_query(x, y, z);
            p.x = x;
            p.y = y;
            p.z = z;
            built_cells.push_back(p);
         end else if (roll < 82) begin
            // revisit an old neighborhood, possibly disturbed by later loads
            p = built_cells[$urandom_range(0, built_cells.size() - 1)];
            queue_query(p.x, p.y, p.z);
         end else begin
            queue_request(vvfe_pkg::FUNC_LOAD, $urandom_range(0, CHUNK_W - 1),
                          $urandom_range(0, CHUNK_H - 1),
                          $urandom_range(0, CHUNK_W - 1), $urandom_range(0, 3));
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // every request taken, then wait for outstanding faces with a bound
      do @(negedge clock); while (pending_reqs.size() != 0 || req_tvalid);
      for (int i = 0; i < 5000 && expected_faces.size() != 0; i++)
         @(negedge clock);
      // a trailing query may still be reading, let it settle
      repeat (40) @(negedge clock);
      if (expected_faces.size() != 0) begin
         $display("%0t ns: faces missing, expected %0d more actual 0",
                  $time, expected_faces.size());
         error_count += expected_faces.size();
      end

      $display("ran %0d loads and %0d queries (%0d with no visible face)",
               load_count, query_count, silent_queries);
      $display("checked %0d face records, %0d errors", face_count, error_count);
      if (error_count == 0) begin
         $display("voxel_visible_face_extract_top verification clean");
      end else begin
         $display("voxel_visible_face_extract_top verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("voxel_visible_face_extract_top verification failed");
      $finish;
   end

endmodule

/* files.f */
design/vvfe_pkg.sv
design/voxel_visible_face_extract_top.sv
dv/voxel_visible_face_extract_top_test.sv
